// ===== rtl/flow_metering_table_top_defines.svh =====
// Assertion macros for the flow metering table.
// Used by flow_metering_table_top.sv; depends on nothing else.
`ifndef FLOW_METERING_TABLE_TOP_DEFINES_SVH
`define FLOW_METERING_TABLE_TOP_DEFINES_SVH

// Plain property checked on every clock edge outside reset.
`define FMT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define FMT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked on the following clock edge.
`define FMT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fmt_pkg.sv =====
// Types and constants of the flow metering table.
// Used by flow_metering_table_top.sv; depends on nothing.
`default_nettype none
package fmt_pkg;
   localparam logic [15:0] IPV4_ETYPE  = 16'h0800;
   localparam logic [7:0]  PROTO_TCP   = 8'd6;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam logic [15:0] LEN_ETH     = 16'd14;
   localparam logic [15:0] LEN_IP      = 16'd34;
   localparam logic [15:0] LEN_TCP     = 16'd54;
   localparam logic [15:0] LEN_UDP     = 16'd42;

   localparam logic [2:0] ST_NOT_IP   = 3'd0;
   localparam logic [2:0] ST_UPDATED  = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_TRUNC    = 3'd4;

   typedef struct packed {
      logic [15:0] frame_len;
      logic [15:0] ether_type;
      logic [15:0] ingress_port;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  ip_proto;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        syn_flag;
      logic        fin_flag;
      logic [63:0] now_ns;
   } req_type;

   typedef struct packed {
      logic        verdict;
      logic [2:0]  status;
      logic [63:0] packet_total;
      logic [63:0] byte_total;
      logic [63:0] start_time;
      logic [63:0] end_time;
   } rsp_type;

   // Key: addresses in the upper 64 bits, ports and protocol below.
   typedef logic [119:0] key_type;

   typedef struct packed {
      logic [63:0] packets;
      logic [63:0] bytes;
      logic [63:0] start;
      logic [63:0] stop;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_CHECK, S_MISS, S_RMW, S_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/flow_metering_table_top.sv =====
// Flow metering table: exact-match flow cache keyed on the five-tuple and ingress port, with counters.
// Depends on fmt_pkg.sv and flow_metering_table_top_defines.svh.
//
// Usage: frames arrive on the req_ channel (valid/ready) as one req_type
// item each; one rsp_type item per frame leaves on the rsp_ channel.
// The block works on one item at a time. Truncated and non-IPv4 frames
// go from the accept straight to S_DONE. For IPv4 frames the key store is
// scanned from entry 0 upward, one entry per S_SCAN/S_CHECK pair, over the
// entries filled so far, until a hit; a hit then does the counter
// read-modify-write in S_RMW, a miss the insert in S_MISS unless the table
// is full, and S_DONE hands the result to the output register. The scan
// through the single-port key memory sets how long an item takes.
// Entries are never removed, so the filled entries are a prefix of the
// store and a fill count stands in for per-entry valid bits.
// Reset empties the table at once (the fill count clears); no clearing pass.
// A stalled receiver holds the result in the output register; the block
// then waits before finishing the next item, and accepts it only when idle.
`default_nettype none
`include "flow_metering_table_top_defines.svh"
module flow_metering_table_top #(
   parameter int TABLE_ENTRIES = 256
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire fmt_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output fmt_pkg::rsp_type     rsp_data
);
   import fmt_pkg::*;

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

   key_type   key_mem [TABLE_ENTRIES];
   entry_type data_mem [TABLE_ENTRIES];

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ctr_ff, ctr_in;
   key_type   key_ff, key_in, key_rd_ff;
   entry_type data_rd_ff;
   logic [15:0] len_ff, len_in;
   logic syn_ff, syn_in, fin_ff, fin_in;
   logic [63:0] now_ff, now_in;
   rsp_type res_ff, res_in, rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic key_rd_en, data_rd_en, key_wr_en, data_wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   entry_type wr_data;

   logic accept, is_tcp, is_udp, trunc;
   logic [15:0] sport, dport;

   assign accept = req_valid && req_ready;
   assign is_tcp = (req_data.ip_proto == PROTO_TCP);
   assign is_udp = (req_data.ip_proto == PROTO_UDP);
   assign sport  = (is_tcp || is_udp) ? req_data.src_port : 16'd0;
   assign dport  = (is_tcp || is_udp) ? req_data.dst_port : 16'd0;
   assign trunc  = (req_data.frame_len < LEN_IP) ||
                   (is_tcp && (req_data.frame_len < LEN_TCP)) ||
                   (is_udp && (req_data.frame_len < LEN_UDP));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ctr_in       = ctr_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      syn_in       = syn_ff;
      fin_in       = fin_ff;
      now_in       = now_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == S_IDLE);
      key_rd_en    = 1'b0;
      data_rd_en   = 1'b0;
      key_wr_en    = 1'b0;
      data_wr_en   = 1'b0;
      rd_addr      = ctr_ff[IW-1:0];
      wr_addr      = ctr_ff[IW-1:0];
      wr_data      = data_rd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in = '0;
               key_in = {req_data.src_addr, req_data.dst_addr, req_data.ingress_port,
                         sport, dport, req_data.ip_proto};
               len_in = req_data.frame_len;
               syn_in = is_tcp && req_data.syn_flag;
               fin_in = is_tcp && req_data.fin_flag;
               now_in = req_data.now_ns;
               ctr_in = '0;
               if (req_data.frame_len < LEN_ETH) begin
                  res_in.verdict = 1'b1;
                  res_in.status  = ST_TRUNC;
                  state_in       = S_DONE;
               end else if (req_data.ether_type != IPV4_ETYPE) begin
                  res_in.status = ST_NOT_IP;
                  state_in      = S_DONE;
               end else if (trunc) begin
                  res_in.verdict = 1'b1;
                  res_in.status  = ST_TRUNC;
                  state_in       = S_DONE;
               end else if (count_ff == '0) begin
                  state_in = S_MISS;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            key_rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (key_rd_ff == key_ff) begin
               data_rd_en = 1'b1;
               state_in   = S_RMW;
            end else begin
               ctr_in   = ctr_ff + 1'b1;
               state_in = ((ctr_ff + 1'b1) == count_ff) ? S_MISS : S_SCAN;
            end
         end
         S_MISS: begin
            if (count_ff == FULL_COUNT) begin
               res_in.status = ST_FULL;
            end else begin
               wr_addr      = count_ff[IW-1:0];
               wr_data      = '{packets: 64'd1, bytes: {48'd0, len_ff},
                                start: syn_ff ? now_ff : 64'd0, stop: 64'd0};
               key_wr_en    = 1'b1;
               data_wr_en   = 1'b1;
               count_in     = count_ff + 1'b1;
               res_in       = '{verdict: 1'b0, status: ST_INSERTED,
                                packet_total: wr_data.packets,
                                byte_total: wr_data.bytes,
                                start_time: wr_data.start, end_time: 64'd0};
            end
            state_in = S_DONE;
         end
         S_RMW: begin
            wr_data.packets = data_rd_ff.packets + 64'd1;
            wr_data.bytes   = data_rd_ff.bytes + {48'd0, len_ff};
            wr_data.stop    = fin_ff ? now_ff : data_rd_ff.stop;
            data_wr_en      = 1'b1;
            res_in          = '{verdict: 1'b0, status: ST_UPDATED,
                                packet_total: wr_data.packets,
                                byte_total: wr_data.bytes,
                                start_time: wr_data.start, end_time: wr_data.stop};
            state_in        = S_DONE;
         end
         S_DONE: begin
            // The finished item waits here while the previous one is stalled.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctr_ff <= ctr_in;
      key_ff <= key_in;
      len_ff <= len_in;
      syn_ff <= syn_in;
      fin_ff <= fin_in;
      now_ff <= now_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (key_rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (data_wr_en) begin
         data_mem[wr_addr] <= wr_data;
      end
      if (data_rd_en) begin
         data_rd_ff <= data_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FMT_ASSERT(a_count_bound, count_ff <= FULL_COUNT, "fill count beyond table size")
   `FMT_ASSERT_IMP(a_scan_in_fill, (state_ff == S_SCAN) || (state_ff == S_CHECK),
      ctr_ff < count_ff, "scan index outside filled entries")
   `FMT_ASSERT_NEXT(a_insert_grows, key_wr_en, count_ff == $past(count_ff) + 1'b1,
      "insert did not advance fill count")
   `FMT_ASSERT_NEXT(a_no_overlap, rsp_valid_ff && !rsp_ready && (state_ff == S_DONE),
      state_ff == S_DONE, "result overwritten while stalled")
endmodule
`default_nettype wire
